// File: sv/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Types, widths and the ordering key shared by the top-k selection block.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int unsigned LOGIT_W    = 16;
  localparam int unsigned IDX_W      = 18;
  localparam int unsigned KCOUNT_W   = 6;
  localparam logic [KCOUNT_W-1:0] KCOUNT_RST = 6'd20;

  // One input request
  typedef struct packed {
    logic [LOGIT_W-1:0] logit;
    logic               end_of_row;
  } stk_in_t;

  // One result request
  typedef struct packed {
    logic [LOGIT_W-1:0] value;
    logic [IDX_W-1:0]   token_index;
    logic               last_of_row;
  } stk_out_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [LOGIT_W-1:0] key;
    logic [LOGIT_W-1:0] value;
    logic [IDX_W-1:0]   idx;
    logic               eor;
  } stk_item_t;

  // One slot of the sorted list
  typedef struct packed {
    logic [LOGIT_W-1:0] key;
    logic [LOGIT_W-1:0] value;
    logic [IDX_W-1:0]   idx;
  } stk_entry_t;

  // Order-preserving key: both zeros map to the same key
  function automatic logic [LOGIT_W-1:0] order_key(input logic [LOGIT_W-1:0] bits);
    logic [LOGIT_W-1:0] b;
    b = bits;
    if (b == 16'h8000) begin
      b = '0;
    end
    if (b[LOGIT_W-1]) begin
      return ~b;
    end
    return b | 16'h8000;
  endfunction

endpackage

// File: sv/stk_fifo.sv
// ----------------------------------------------------------------------------
// stk_fifo
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module stk_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and count update, wrapping at DEPTH
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/stk_front.sv
// ----------------------------------------------------------------------------
// stk_front
// Accepts logits, builds the ordering key and numbers items within a row.
// ----------------------------------------------------------------------------
module stk_front #(
  parameter int unsigned MAX_VOCAB = 262144
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stk_pkg::stk_in_t  in_item_i,
  input  logic              push_i,
  output logic              full_o,
  output stk_pkg::stk_item_t q_item_o,
  output logic              q_push_o,
  input  logic              q_full_i
);
  import stk_pkg::*;

  localparam int unsigned PW = $clog2(MAX_VOCAB);
  localparam int unsigned XW = (PW > IDX_W) ? PW : IDX_W;

  logic [PW-1:0] pos_q, pos_d;
  logic [XW-1:0] pos_ext;
  logic          accept;

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign pos_ext  = XW'(pos_q);

  // Classified request towards the back end
  always_comb begin
    q_item_o.key   = order_key(in_item_i.logit);
    q_item_o.value = in_item_i.logit;
    q_item_o.idx   = pos_ext[IDX_W-1:0];
    q_item_o.eor   = in_item_i.end_of_row;
  end

  // Position counter: saturates at the last position, clears after row end
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (in_item_i.end_of_row) begin
        pos_d = '0;
      end else if (pos_q != PW'(MAX_VOCAB - 1)) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: sv/stk_back.sv
// ----------------------------------------------------------------------------
// stk_back
// Sorted best-list with parallel compare-and-shift insertion and row drain.
// ----------------------------------------------------------------------------
module stk_back #(
  parameter int unsigned K_MAX = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [stk_pkg::KCOUNT_W-1:0]  k_count_i,
  input  stk_pkg::stk_item_t            q_item_i,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  output stk_pkg::stk_out_t             o_item_o,
  output logic                          o_push_o,
  input  logic                          o_full_i
);
  import stk_pkg::*;

  localparam int unsigned CW = $clog2(K_MAX + 1);
  localparam int unsigned NW = (CW > KCOUNT_W) ? CW : KCOUNT_W;

  typedef enum logic [1:0] {
    ST_INSERT = 2'b01,
    ST_DRAIN  = 2'b10
  } state_e;

  state_e        state_q, state_d;
  stk_entry_t    list_q [K_MAX];
  stk_entry_t    list_d [K_MAX];
  stk_entry_t    new_entry;
  logic [K_MAX-1:0] ge;
  logic [CW-1:0] fill_q, fill_d, fill_inc;
  logic [CW-1:0] rem_q, rem_d;
  logic [NW-1:0] k_ext, keff, fill_ext, n_ext;
  logic          do_insert, do_emit;

  assign new_entry.key   = q_item_i.key;
  assign new_entry.value = q_item_i.value;
  assign new_entry.idx   = q_item_i.idx;

  assign do_insert = (state_q == ST_INSERT) && !q_empty_i;
  assign do_emit   = (state_q == ST_DRAIN) && !o_full_i;
  assign q_pop_o   = do_insert;
  assign o_push_o  = do_emit;

  // Head of the list goes out during drain
  assign o_item_o.value       = list_q[0].value;
  assign o_item_o.token_index = list_q[0].idx;
  assign o_item_o.last_of_row = (rem_q == CW'(1));

  // Slots holding a key at least as large as the new one stay put
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      ge[i] = (CW'(i) < fill_q) && (list_q[i].key >= q_item_i.key);
    end
  end

  assign fill_inc = (fill_q == CW'(K_MAX)) ? fill_q : fill_q + 1'b1;

  // Effective count: zero acts as one, above K_MAX saturates
  assign k_ext    = NW'(k_count_i);
  assign keff     = (k_ext == '0) ? NW'(1) :
                    ((k_ext > NW'(K_MAX)) ? NW'(K_MAX) : k_ext);
  assign fill_ext = NW'(fill_inc);
  assign n_ext    = (fill_ext < keff) ? fill_ext : keff;

  // List update: insert, or shift up by one per emitted result
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    rem_d   = rem_q;
    for (int i = 0; i < K_MAX; i++) begin
      list_d[i] = list_q[i];
    end
    unique case (state_q)
      ST_INSERT: begin
        if (do_insert) begin
          for (int i = 0; i < K_MAX; i++) begin
            if (!ge[i]) begin
              if (i == 0) begin
                list_d[i] = new_entry;
              end else if (ge[i-1]) begin
                list_d[i] = new_entry;
              end else begin
                list_d[i] = list_q[i-1];
              end
            end
          end
          fill_d = fill_inc;
          if (q_item_i.eor) begin
            rem_d   = n_ext[CW-1:0];
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (do_emit) begin
          for (int i = 0; i < K_MAX - 1; i++) begin
            list_d[i] = list_q[i+1];
          end
          rem_d = rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            fill_d  = '0;
            state_d = ST_INSERT;
          end
        end
      end
      default: begin
        state_d = ST_INSERT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INSERT;
      fill_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
    end
  end

  // List payload, no reset: slots at or past the fill count are ignored
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < K_MAX; i++) begin
      list_q[i] <= list_d[i];
    end
  end

endmodule

// File: sv/streaming_top_k_select_core.sv
// Path: an accepted item passes through the item queue before it is written into the list; the
//   results of a row leave the list head for the result queue once its end-of-row item is inserted.
// Throughput: one logit per cycle, set by the compare-and-shift list, while no drain or full queue holds
//   the flow; each row end holds the list while its results are drained.
// Reset: fill count and position cleared, k_count set to 20; no clearing pass is needed.
// ----------------------------------------------------------------------------
// streaming_top_k_select_core
// Streaming top-k selection over bf16 logits with an APB register port.
// ----------------------------------------------------------------------------
module streaming_top_k_select_core #(
  parameter int unsigned K_MAX     = 32,
  parameter int unsigned MAX_VOCAB = 262144
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input queue side
  input  stk_pkg::stk_in_t  in_item_i,
  input  logic              push,
  output logic              full,
  // result queue side
  output stk_pkg::stk_out_t out_item_o,
  output logic              empty,
  input  logic              pop,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import stk_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned ODEPTH = 2;

  logic [KCOUNT_W-1:0] k_count_q, k_count_d;
  stk_item_t           fq_wdata, fq_rdata;
  logic                fq_push, fq_full, fq_pop, fq_empty;
  stk_out_t            oq_wdata;
  logic                oq_push, oq_full;

  // Register port: single register, every address maps to k_count
  assign pready = 1'b1;
  assign prdata = 32'(k_count_q);
  assign k_count_d = (psel && penable && pwrite && (paddr == 2'b00 || paddr != 2'b00)) ?
                     pwdata[KCOUNT_W-1:0] : k_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_count_q <= KCOUNT_RST;
    end else begin
      k_count_q <= k_count_d;
    end
  end

  // Front end: key and position
  stk_front #(
    .MAX_VOCAB (MAX_VOCAB)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .push_i    (push),
    .full_o    (full),
    .q_item_o  (fq_wdata),
    .q_push_o  (fq_push),
    .q_full_i  (fq_full)
  );

  // Decoupling queue between front and back
  stk_fifo #(
    .WIDTH ($bits(stk_item_t)),
    .DEPTH (QDEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_wdata),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .rdata_o (fq_rdata),
    .empty_o (fq_empty)
  );

  // Back end: sorted list and drain
  stk_back #(
    .K_MAX (K_MAX)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .k_count_i (k_count_q),
    .q_item_i  (fq_rdata),
    .q_empty_i (fq_empty),
    .q_pop_o   (fq_pop),
    .o_item_o  (oq_wdata),
    .o_push_o  (oq_push),
    .o_full_i  (oq_full)
  );

  // Result queue
  stk_fifo #(
    .WIDTH ($bits(stk_out_t)),
    .DEPTH (ODEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .wdata_i (oq_wdata),
    .full_o  (oq_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

// File: tb/streaming_top_k_select_core_test.sv
// ----------------------------------------------------------------------------
// streaming_top_k_select_core_test
// Self-checking bench for the streaming top-k block. Logit requests are pushed
// with random gaps, a shadow ranking list predicts every result request, and
// results are popped with random stalls and compared field by field. k_count
// is moved through its extremes over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module streaming_top_k_select_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stk_pkg::*;

  localparam int unsigned K_MAX         = 32;
  localparam int unsigned MAX_VOCAB     = 262144;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HALF_PHASE    = 14;
  localparam int unsigned PHASES        = 6;
  localparam logic [1:0]  REG_K_COUNT   = 2'd0;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  stk_in_t     logit_req = '0;
  logic        push      = 1'b0;
  logic        full;
  stk_out_t    result_req;
  logic        empty;
  logic        pop       = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [1:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Logit requests waiting to go in, result requests predicted to come out
  stk_in_t  logits_to_send[$];
  stk_out_t ranking_due[$];

  // Shadow of the ranking list, row position and k_count
  stk_entry_t          ranked[K_MAX];
  int unsigned         ranked_n = 0;
  int unsigned         row_pos  = 0;
  logic [KCOUNT_W-1:0] k_shadow = KCOUNT_RST;

  bit          calm       = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stalled    = 0;

  streaming_top_k_select_core #(
    .K_MAX    (K_MAX),
    .MAX_VOCAB(MAX_VOCAB)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (logit_req),
    .push      (push),
    .full      (full),
    .out_item_o(result_req),
    .empty     (empty),
    .pop       (pop),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Sign-magnitude to unsigned order; -0 folds onto +0
  function automatic logic [LOGIT_W-1:0] rank_key(input logic [LOGIT_W-1:0] bits);
    if (bits[LOGIT_W-1] && bits[LOGIT_W-2:0] != '0) begin
      return ~bits;
    end
    return {1'b1, bits[LOGIT_W-2:0]};
  endfunction

  // Insert one logit into the shadow list; at row end queue the ranked results
  task automatic rank_logit(input stk_in_t req);
    logic [LOGIT_W-1:0] key;
    int unsigned        at;
    int unsigned        i;
    int unsigned        keep;
    stk_out_t           res;
    key = rank_key(req.logit);
    at  = 0;
    // equal keys go behind: lower position, or earlier arrival, ranks higher
    while (at < ranked_n && ranked[at].key >= key) begin
      at++;
    end
    if (at < K_MAX) begin
      i = (ranked_n < K_MAX) ? ranked_n : K_MAX - 1;
      while (i > at) begin
        ranked[i] = ranked[i-1];
        i--;
      end
      ranked[at].key   = key;
      ranked[at].value = req.logit;
      ranked[at].idx   = row_pos[IDX_W-1:0];
      if (ranked_n < K_MAX) begin
        ranked_n++;
      end
    end
    if (row_pos < MAX_VOCAB - 1) begin
      row_pos++;
    end
    if (req.end_of_row) begin
      // zero acts as one, anything above the list depth as the full list
      keep = (k_shadow == 0) ? 1 : (k_shadow > K_MAX) ? K_MAX : k_shadow;
      if (keep > ranked_n) begin
        keep = ranked_n;
      end
      for (i = 0; i < keep; i++) begin
        res.value       = ranked[i].value;
        res.token_index = ranked[i].idx;
        res.last_of_row = (i + 1 == keep);
        ranking_due.push_back(res);
      end
      ranked_n = 0;
      row_pos  = 0;
    end
  endtask

  // Logit driver: predict on acceptance, then present the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      logit_req <= '0;
    end else begin
      if (push && !full) begin
        rank_logit(logit_req);
      end
      if (!push || !full) begin
        if (logits_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          logit_req <= logits_to_send.pop_front();
          push      <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each popped request against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    stk_out_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (ranking_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result_req);
          mismatches++;
        end else begin
          want = ranking_due.pop_front();
          if (result_req.value !== want.value) begin
            $display("%0t: value expected %h got %h", $time, want.value, result_req.value);
            mismatches++;
          end
          if (result_req.token_index !== want.token_index) begin
            $display("%0t: token_index expected %0d got %0d", $time, want.token_index,
                     result_req.token_index);
            mismatches++;
          end
          if (result_req.last_of_row !== want.last_of_row) begin
            $display("%0t: last_of_row expected %b got %b", $time, want.last_of_row,
                     result_req.last_of_row);
            mismatches++;
          end
        end
      end
      pop <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog: too long without any request moving ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stalled <= 0;
      end else if (stalled == STALL_LIMIT) begin
        $display("streaming_top_k_select_core_test NOT OK");
        $finish;
      end else begin
        stalled <= stalled + 1;
      end
    end
  end

  // Wait until every request is in and every result is out, then let the block go quiet
  task automatic settle();
    do begin
      @(posedge clk_i);
    end while (logits_to_send.size() != 0 || push || ranking_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of k_count followed by a read back
  task automatic set_k(input logic [KCOUNT_W-1:0] k);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_K_COUNT;
    pwdata  <= 32'(k);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    k_shadow = k;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[KCOUNT_W-1:0] !== k) begin
      $display("%0t: k_count read expected %0d got %0d", $time, k, prdata[KCOUNT_W-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send(input logic [LOGIT_W-1:0] v, input logic eor);
    stk_in_t req;
    req.logit      = v;
    req.end_of_row = eor;
    logits_to_send.push_back(req);
  endtask

  // Mix of zeros, infinities, NaN extremes, near ties and raw patterns
  function automatic logic [LOGIT_W-1:0] pick_logit();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7F80;
      3:       return 16'hFF80;
      4:       return 16'h7FFF;
      5:       return 16'hFFFF;
      6, 7:    return {1'($urandom_range(1)), 15'h3F80 + 15'($urandom_range(3))};
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue whole rows, mostly short, now and then past the list depth
  task automatic queue_rows(input int unsigned count);
    int unsigned queued;
    int unsigned len;
    int unsigned i;
    queued = 0;
    while (queued < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(33, 48) : $urandom_range(1, 12);
      for (i = 0; i < len; i++) begin
        send(pick_logit(), i == len - 1);
      end
      queued += len;
    end
  endtask

  initial begin
    logic [KCOUNT_W-1:0] k_plan[PHASES];
    int unsigned         p;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset k_count: zeros tie, infinities, NaN extremes, smallest magnitudes
    send(16'h0000, 1'b0);
    send(16'h8000, 1'b0);
    send(16'h3F80, 1'b0);
    send(16'hFF80, 1'b0);
    send(16'h7F80, 1'b0);
    send(16'hFFFF, 1'b0);
    send(16'h7FFF, 1'b0);
    send(16'h0001, 1'b0);
    send(16'h8001, 1'b0);
    send(16'h3F80, 1'b1);
    // one-logit row
    send(16'hC000, 1'b1);
    settle();

    // k_count of one
    set_k(6'd1);
    send(16'h1234, 1'b0);
    send(16'h5678, 1'b0);
    send(16'hABCD, 1'b0);
    send(16'h5678, 1'b1);
    settle();

    // zero acts as one; -0 then +0 tie on position
    set_k(6'd0);
    send(16'h8000, 1'b0);
    send(16'h0000, 1'b0);
    send(16'hFFFF, 1'b1);
    settle();

    // k_count changed part way through a row
    send(16'h4000, 1'b0);
    send(16'hC120, 1'b0);
    send(16'h0080, 1'b0);
    send(16'h7F7F, 1'b0);
    send(16'h4000, 1'b0);
    settle();
    set_k(6'd2);
    send(16'h2000, 1'b0);
    send(16'h4000, 1'b1);
    settle();

    // Random rows over several k_count settings, both sides pausing for a full drain
    k_plan[0] = 6'd32;
    k_plan[1] = 6'd63;
    k_plan[2] = 6'd33;
    k_plan[3] = 6'($urandom_range(63));
    k_plan[4] = 6'd7;
    k_plan[5] = KCOUNT_RST;
    for (p = 0; p < PHASES; p++) begin
      set_k(k_plan[p]);
      calm = (p == 2);
      queue_rows(HALF_PHASE);
      settle();
      queue_rows(HALF_PHASE);
      settle();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("streaming_top_k_select_core_test OK");
    end else begin
      $display("streaming_top_k_select_core_test NOT OK");
    end
    $finish;
  end

endmodule
